@@ src/svge_pkg.sv @@
// state vector gate engine: shared package
// request codes, product part codes and the control struct of the shared unit
// no dependencies
`default_nettype none
package svge_pkg;

  // request kinds carried on in_tuser
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_MATRIX = 3'd1;
  localparam logic [2:0] REQ_SINGLE = 3'd2;
  localparam logic [2:0] REQ_TWO    = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // which real product the shared multiplier forms this cycle
  localparam logic [2:0] PART_RR  = 3'd0; // mr*ar, added to real sum
  localparam logic [2:0] PART_II  = 3'd1; // mi*ai, taken from real sum
  localparam logic [2:0] PART_RI  = 3'd2; // mr*ai, added to imaginary sum
  localparam logic [2:0] PART_IR  = 3'd3; // mi*ar, added to imaginary sum
  localparam logic [2:0] PART_SQR = 3'd4; // ar*ar, added to squared magnitude
  localparam logic [2:0] PART_SQI = 3'd5; // ai*ai, added to squared magnitude

  // fraction bits of a matrix entry
  localparam int MAT_FRAC = 14;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic       issue;
    logic       clr;
    logic [2:0] part;
  } mac_ctrl_t;

endpackage
`default_nettype wire

@@ src/svge_ram.sv @@
// state vector gate engine: generic single-port-write ram
// one write and one registered read per cycle; no dependencies
`default_nettype none
module svge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ src/svge_mac.sv @@
// state vector gate engine: shared multiplier with rounding, accumulation,
// saturation and squared-magnitude scaling; uses svge_pkg
`default_nettype none
module svge_mac #(
  parameter int AMP_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire svge_pkg::mac_ctrl_t         ctrl,
  input  wire logic signed [AMP_WIDTH-1:0] amp_re,
  input  wire logic signed [AMP_WIDTH-1:0] amp_im,
  input  wire logic signed [15:0]          mat_re,
  input  wire logic signed [15:0]          mat_im,
  output logic signed      [AMP_WIDTH-1:0] sat_re,
  output logic signed      [AMP_WIDTH-1:0] sat_im,
  output logic             [31:0]          prob
);

  localparam int MW    = (AMP_WIDTH > 16) ? AMP_WIDTH : 16;
  localparam int PW    = 2 * MW;
  localparam int ACW   = 2 * MW - 10;
  localparam int SQW   = 2 * AMP_WIDTH;
  localparam int TWO_F = 2 * (AMP_WIDTH - 2);
  localparam int PR_R  = (TWO_F > 28) ? (TWO_F - 28) : 0;
  localparam int PR_L  = (TWO_F > 28) ? 0 : (28 - TWO_F);
  localparam logic [63:0] PR_HALF = (64'd1 << PR_R) >> 1;
  localparam logic signed [PW:0] RND =
    (PW + 1)'(1) << (svge_pkg::MAT_FRAC - 1);
  localparam logic signed [ACW-1:0] SAT_HI =
    {{(ACW - AMP_WIDTH + 1){1'b0}}, {(AMP_WIDTH - 1){1'b1}}};
  localparam logic signed [ACW-1:0] SAT_LO = ~SAT_HI;

  logic signed [MW-1:0]  a_op, b_op;
  logic signed [PW-1:0]  prod_r;
  logic                  pv_r;
  logic [2:0]            ppart_r;
  logic signed [PW:0]    pq, pq_sh;
  logic signed [ACW-1:0] rp;
  logic signed [ACW-1:0] sr_r, si_r;
  logic [SQW-1:0]        sq_r;
  logic [63:0]           sq64;

  // operand selection per product part
  always_comb begin
    a_op = MW'(amp_re);
    b_op = MW'(mat_re);
    case (ctrl.part)
      svge_pkg::PART_RR:  begin a_op = MW'(amp_re); b_op = MW'(mat_re); end
      svge_pkg::PART_II:  begin a_op = MW'(amp_im); b_op = MW'(mat_im); end
      svge_pkg::PART_RI:  begin a_op = MW'(amp_im); b_op = MW'(mat_re); end
      svge_pkg::PART_IR:  begin a_op = MW'(amp_re); b_op = MW'(mat_im); end
      svge_pkg::PART_SQR: begin a_op = MW'(amp_re); b_op = MW'(amp_re); end
      svge_pkg::PART_SQI: begin a_op = MW'(amp_im); b_op = MW'(amp_im); end
      default:            begin a_op = MW'(amp_re); b_op = MW'(mat_re); end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctrl.issue;
    end
    prod_r  <= a_op * b_op;
    ppart_r <= ctrl.part;
  end

  // round half up: floor((p + half) / 2^frac)
  assign pq    = (PW + 1)'(prod_r) + RND;
  assign pq_sh = pq >>> svge_pkg::MAT_FRAC;
  assign rp    = ACW'(pq_sh);

  // exact accumulation of rounded products and of unrounded squares
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      sr_r <= '0;
      si_r <= '0;
      sq_r <= '0;
    end else if (pv_r) begin
      case (ppart_r)
        svge_pkg::PART_RR:  sr_r <= sr_r + rp;
        svge_pkg::PART_II:  sr_r <= sr_r - rp;
        svge_pkg::PART_RI:  si_r <= si_r + rp;
        svge_pkg::PART_IR:  si_r <= si_r + rp;
        svge_pkg::PART_SQR: sq_r <= sq_r + prod_r[SQW-1:0];
        svge_pkg::PART_SQI: sq_r <= sq_r + prod_r[SQW-1:0];
        default:            sr_r <= sr_r;
      endcase
    end
  end

  // saturate sums to the amplitude format
  always_comb begin
    if (sr_r > SAT_HI)      sat_re = AMP_WIDTH'(SAT_HI);
    else if (sr_r < SAT_LO) sat_re = AMP_WIDTH'(SAT_LO);
    else                    sat_re = AMP_WIDTH'(sr_r);
    if (si_r > SAT_HI)      sat_im = AMP_WIDTH'(SAT_HI);
    else if (si_r < SAT_LO) sat_im = AMP_WIDTH'(SAT_LO);
    else                    sat_im = AMP_WIDTH'(si_r);
  end

  // rescale squared magnitude to Q4.28
  assign sq64 = 64'(sq_r);
  assign prob = 32'(((sq64 + PR_HALF) >> PR_R) << PR_L);

endmodule
`default_nettype wire

@@ src/state_vector_gate_engine.sv @@
// state vector gate engine: top level with sequencer, gate matrix, config
// uses svge_pkg, svge_ram, svge_mac
//
// channel | dir | ports                   | content
// in      | in  | in_tvalid/tready/tdata  | one request, kind on in_tuser
// out     | out | out_tvalid/tready/tdata | one result, status on out_tuser
// cfg     | in  | cfg_p*                  | qubit_count at byte address 0
//
// clear: one store write a cycle over the whole store; after reset the
// same pass runs before in_tready rises
// single gate and two-qubit gate: every vector entry is built on the one
// shared multiplier, four real products per term
// read: a store read, then the squared magnitude; matrix write and rejects go straight to the result
// in_tready is low while a request is at work; a pending result does not
// block the next transfer in, only its completion
`default_nettype none
module state_vector_gate_engine #(
  parameter int QUBIT_LIMIT = 8,
  parameter int AMP_WIDTH   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // row[1:0] col[3:2] entry_re[19:4] entry_im[35:20] target_qubit[38:36]
  // control_qubit[41:39] basis_index[49:42], zero above
  input  wire logic [55:0] in_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // amp_re[15:0] amp_im[31:16] probability[63:32]
  output logic [63:0]      out_tdata,
  // status[0]
  output logic [0:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int ADDR_W = QUBIT_LIMIT;
  localparam int DEPTH  = 1 << QUBIT_LIMIT;
  localparam int CNT_W  = QUBIT_LIMIT + 1;
  localparam int DW     = 2 * AMP_WIDTH;
  localparam int EW     = (AMP_WIDTH > 16) ? AMP_WIDTH : 16;
  localparam int IXW    = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [DW-1:0] ONE_WORD = DW'(1) << (AMP_WIDTH - 2);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_MAC   = 4'd4;
  localparam logic [3:0] S_FLUSH = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_SQ0   = 4'd8;
  localparam logic [3:0] S_SQ1   = 4'd9;
  localparam logic [3:0] S_SQ2   = 4'd10;
  localparam logic [3:0] S_SQ3   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]        state_r;
  logic [3:0]        qc_r;
  logic signed [15:0] mat_re_r [16];
  logic signed [15:0] mat_im_r [16];
  logic [CNT_W-1:0]  i_r;
  logic [ADDR_W-1:0] base_r, tm_r, cm_r, clr_cnt_r;
  logic              two_r, emit_r;
  logic [2:0]        k_r;
  logic [3:0]        p_r;
  logic [1:0]        b_r;
  logic [DW-1:0]     grp_r [4];
  logic              res_status_r;
  logic [15:0]       res_re_r, res_im_r;
  logic [31:0]       res_prob_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic [63:0]       out_data_r;

  // input fields
  logic [2:0]  f_req;
  logic [1:0]  f_row, f_col;
  logic [15:0] f_ere, f_eim;
  logic [2:0]  f_tq, f_cq;
  logic [7:0]  f_idx;
  assign f_req = in_tuser;
  assign f_row = in_tdata[1:0];
  assign f_col = in_tdata[3:2];
  assign f_ere = in_tdata[19:4];
  assign f_eim = in_tdata[35:20];
  assign f_tq  = in_tdata[38:36];
  assign f_cq  = in_tdata[41:39];
  assign f_idx = in_tdata[49:42];

  // active qubits and vector length
  logic [3:0]       n_act;
  logic [CNT_W-1:0] dim;
  logic [IXW-1:0]   idx_ext;
  assign n_act   = (qc_r > 4'(QUBIT_LIMIT)) ? 4'(QUBIT_LIMIT) : qc_r;
  assign dim     = CNT_W'(1) << n_act;
  assign idx_ext = IXW'(f_idx);

  logic bad_t, bad_c, bad_idx;
  assign bad_t   = ({1'b0, f_tq} >= n_act);
  assign bad_c   = ({1'b0, f_cq} >= n_act) || (f_tq == f_cq);
  assign bad_idx = (idx_ext >= IXW'(dim));

  logic in_xfer, out_load;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // address of group member k
  function automatic logic [ADDR_W-1:0] memb(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] cm,
                                             input logic [ADDR_W-1:0] tm,
                                             input logic [1:0] k);
    logic [ADDR_W-1:0] a;
    a = base;
    if (k[1]) a = a | cm;
    if (k[0]) a = a | tm;
    return a;
  endfunction

  logic [2:0] g_last;
  logic [3:0] p_last;
  logic [1:0] b_last;
  assign g_last = two_r ? 3'd4 : 3'd2;
  assign p_last = two_r ? 4'd15 : 4'd7;
  assign b_last = two_r ? 2'd3 : 2'd1;

  // store ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;
  logic signed [AMP_WIDTH-1:0] sat_re, sat_im;
  logic [31:0]       mac_prob;

  assign ram_we    = (state_r == S_CLR) || (state_r == S_WB);
  assign ram_waddr = (state_r == S_CLR) ? clr_cnt_r : memb(base_r, cm_r, tm_r, b_r);
  assign ram_wdata = (state_r == S_CLR) ? ((clr_cnt_r == '0) ? ONE_WORD : '0)
                                        : {sat_im, sat_re};

  always_comb begin
    if (state_r == S_IDLE)      ram_raddr = idx_ext[ADDR_W-1:0];
    else if (state_r == S_LOAD) ram_raddr = memb(base_r, cm_r, tm_r, k_r[1:0]);
    else                        ram_raddr = '0;
  end

  svge_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared unit control and operands
  svge_pkg::mac_ctrl_t mac_ctrl;
  logic [1:0] op_j;
  logic [3:0] mat_idx;
  logic [DW-1:0] op_amp;
  assign op_j    = (state_r == S_MAC) ? p_r[3:2] : 2'd0;
  assign mat_idx = {b_r, p_r[3:2]};
  assign op_amp  = grp_r[op_j];

  always_comb begin
    mac_ctrl.issue = 1'b0;
    mac_ctrl.clr   = (state_r == S_IDLE) || (state_r == S_WB);
    mac_ctrl.part  = svge_pkg::PART_RR;
    if (state_r == S_MAC) begin
      mac_ctrl.issue = 1'b1;
      case (p_r[1:0])
        2'd0:    mac_ctrl.part = svge_pkg::PART_RR;
        2'd1:    mac_ctrl.part = svge_pkg::PART_II;
        2'd2:    mac_ctrl.part = svge_pkg::PART_RI;
        default: mac_ctrl.part = svge_pkg::PART_IR;
      endcase
    end else if (state_r == S_SQ0) begin
      mac_ctrl.issue = 1'b1;
      mac_ctrl.part  = svge_pkg::PART_SQR;
    end else if (state_r == S_SQ1) begin
      mac_ctrl.issue = 1'b1;
      mac_ctrl.part  = svge_pkg::PART_SQI;
    end
  end

  svge_mac #(.AMP_WIDTH(AMP_WIDTH)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .amp_re (op_amp[AMP_WIDTH-1:0]),
    .amp_im (op_amp[DW-1:AMP_WIDTH]),
    .mat_re (mat_re_r[mat_idx]),
    .mat_im (mat_im_r[mat_idx]),
    .sat_re (sat_re),
    .sat_im (sat_im),
    .prob   (mac_prob)
  );

  // sequencer next state
  logic [3:0] state_nxt;
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_cnt_r == {ADDR_W{1'b1}}) state_nxt = emit_r ? S_FIN : S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          case (f_req)
            svge_pkg::REQ_CLEAR:  state_nxt = S_CLR;
            svge_pkg::REQ_SINGLE: state_nxt = bad_t ? S_FIN : S_SCAN;
            svge_pkg::REQ_TWO:    state_nxt = (bad_t || bad_c) ? S_FIN : S_SCAN;
            svge_pkg::REQ_READ:   state_nxt = bad_idx ? S_FIN : S_RDW;
            default:              state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (i_r == dim) state_nxt = S_FIN;
        else if ((i_r[ADDR_W-1:0] & (tm_r | cm_r)) == '0) state_nxt = S_LOAD;
      end
      S_LOAD:  if (k_r == g_last) state_nxt = S_MAC;
      S_MAC:   if (p_r == p_last) state_nxt = S_FLUSH;
      S_FLUSH: state_nxt = S_WB;
      S_WB:    state_nxt = (b_r == b_last) ? S_SCAN : S_MAC;
      S_RDW:   state_nxt = S_SQ0;
      S_SQ0:   state_nxt = S_SQ1;
      S_SQ1:   state_nxt = S_SQ2;
      S_SQ2:   state_nxt = S_SQ3;
      S_SQ3:   state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer registers and request decode
  logic [2:0] km1;
  assign km1 = k_r - 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      emit_r    <= 1'b0;
      for (int m = 0; m < 16; m++) begin
        mat_re_r[m] <= '0;
        mat_im_r[m] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_CLR: clr_cnt_r <= clr_cnt_r + 1'b1;
        S_IDLE: begin
          if (in_xfer) begin
            res_re_r     <= '0;
            res_im_r     <= '0;
            res_prob_r   <= '0;
            i_r          <= '0;
            case (f_req)
              svge_pkg::REQ_CLEAR: begin
                res_status_r <= 1'b0;
                clr_cnt_r    <= '0;
                emit_r       <= 1'b1;
              end
              svge_pkg::REQ_MATRIX: begin
                res_status_r             <= 1'b0;
                mat_re_r[{f_row, f_col}] <= f_ere;
                mat_im_r[{f_row, f_col}] <= f_eim;
              end
              svge_pkg::REQ_SINGLE: begin
                res_status_r <= bad_t;
                tm_r         <= ADDR_W'(1) << f_tq;
                cm_r         <= '0;
                two_r        <= 1'b0;
              end
              svge_pkg::REQ_TWO: begin
                res_status_r <= bad_t || bad_c;
                tm_r         <= ADDR_W'(1) << f_tq;
                cm_r         <= ADDR_W'(1) << f_cq;
                two_r        <= 1'b1;
              end
              svge_pkg::REQ_READ: res_status_r <= bad_idx;
              default:            res_status_r <= 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          if (i_r != dim) begin
            if ((i_r[ADDR_W-1:0] & (tm_r | cm_r)) == '0) begin
              base_r <= i_r[ADDR_W-1:0];
              k_r    <= '0;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        S_LOAD: begin
          k_r <= k_r + 1'b1;
          if (k_r != 3'd0) grp_r[km1[1:0]] <= ram_rdata;
          p_r <= '0;
          b_r <= '0;
        end
        S_MAC: p_r <= p_r + 1'b1;
        S_FLUSH: p_r <= '0;
        S_WB: begin
          if (b_r == b_last) i_r <= i_r + 1'b1;
          else               b_r <= b_r + 1'b1;
        end
        S_RDW: grp_r[0] <= ram_rdata;
        S_SQ3: begin
          res_re_r   <= 16'(EW'($signed(grp_r[0][AMP_WIDTH-1:0])));
          res_im_r   <= 16'(EW'($signed(grp_r[0][DW-1:AMP_WIDTH])));
          res_prob_r <= mac_prob;
        end
        S_FIN: emit_r <= 1'b0;
        default: emit_r <= emit_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= {res_prob_r, res_im_r, res_re_r};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_status_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qc_r <= 4'd4;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      qc_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {28'd0, qc_r};

`ifndef SYNTH
  // no store write while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && state_r == S_IDLE))
    else $error("store written while idle");

  // scan counter never passes the vector length
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (i_r <= dim))
    else $error("scan index beyond vector length");

  // product counter stays within the group's product count
  a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (p_r <= p_last))
    else $error("product counter overrun");

  // control and target masks never overlap during a gate pass
  a_masks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((tm_r & cm_r) == '0))
    else $error("control and target overlap");

  // an accepted request always starts work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("request transfer left sequencer idle");
`endif

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for state_vector_gate_engine: random and directed requests, own state-vector model
// depends on svge_pkg and the engine RTL; no other files
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;
  localparam int UNKNOWN_REQ = 5;

  // one request as it travels on the input channel
  typedef struct {
    logic [2:0]  kind;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [15:0] ere;
    logic [15:0] eim;
    logic [2:0]  tq;
    logic [2:0]  cq;
    logic [7:0]  idx;
  } request_t;

  // one expected result
  typedef struct {
    logic        status;
    logic [15:0] amp_re;
    logic [15:0] amp_im;
    logic [31:0] prob;
  } outcome_t;

  // state vector model plus the queue of outcomes still to arrive
  class amp_scoreboard;
    int unsigned qubits;
    longint vec_re[256];
    longint vec_im[256];
    longint mat_re[16];
    longint mat_im[16];
    outcome_t awaited[$];
    string faults[$];

    function new();
      qubits = 4;
      ground();
      foreach (mat_re[k]) begin
        mat_re[k] = 0;
        mat_im[k] = 0;
      end
    endfunction

    function void ground();
      foreach (vec_re[k]) begin
        vec_re[k] = 0;
        vec_im[k] = 0;
      end
      vec_re[0] = 64'sd1 <<< 14;
    endfunction

    function longint rnd(longint p);
      return (p + 8192) >>> 14;
    endfunction

    function longint clip(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // product of matrix entry m and amplitude k added to the running sums
    function void mul_add(int m, int k, ref longint sr, ref longint si);
      sr += rnd(mat_re[m] * vec_re[k]) - rnd(mat_im[m] * vec_im[k]);
      si += rnd(mat_re[m] * vec_im[k]) + rnd(mat_im[m] * vec_re[k]);
    endfunction

    function void run_gate(bit pair, int c, int t, int dim);
      longint nre[256];
      longint nim[256];
      longint sr, si;
      int cm, tm, b, k;
      cm = pair ? (1 << c) : 0;
      tm = 1 << t;
      for (int i = 0; i < dim; i++) begin
        sr = 0;
        si = 0;
        b = (((i & cm) != 0) ? 2 : 0) | (((i & tm) != 0) ? 1 : 0);
        if (pair) begin
          for (int j = 0; j < 4; j++) begin
            k = i & ~(cm | tm);
            if (j & 2) k |= cm;
            if (j & 1) k |= tm;
            mul_add(b * 4 + j, k, sr, si);
          end
        end else begin
          mul_add(b * 4, i & ~tm, sr, si);
          mul_add(b * 4 + 1, i | tm, sr, si);
        end
        nre[i] = clip(sr);
        nim[i] = clip(si);
      end
      for (int i = 0; i < dim; i++) begin
        vec_re[i] = nre[i];
        vec_im[i] = nim[i];
      end
    endfunction

    // accepted request: update the model and queue its outcome
    function void note_request(request_t r);
      outcome_t o;
      int n, dim;
      longint sq;
      n = (qubits > 8) ? 8 : qubits;
      dim = 1 << n;
      o = '{1'b0, 16'h0, 16'h0, 32'h0};
      case (r.kind)
        svge_pkg::REQ_CLEAR: ground();
        svge_pkg::REQ_MATRIX: begin
          mat_re[r.row * 4 + r.col] = longint'($signed(r.ere));
          mat_im[r.row * 4 + r.col] = longint'($signed(r.eim));
        end
        svge_pkg::REQ_SINGLE: begin
          if (r.tq >= n) o.status = 1'b1;
          else run_gate(1'b0, 0, r.tq, dim);
        end
        svge_pkg::REQ_TWO: begin
          if (r.tq >= n || r.cq >= n || r.tq == r.cq) o.status = 1'b1;
          else run_gate(1'b1, r.cq, r.tq, dim);
        end
        svge_pkg::REQ_READ: begin
          if (r.idx >= dim) o.status = 1'b1;
          else begin
            sq = vec_re[r.idx] * vec_re[r.idx] + vec_im[r.idx] * vec_im[r.idx];
            o.amp_re = vec_re[r.idx][15:0];
            o.amp_im = vec_im[r.idx][15:0];
            o.prob = sq[31:0];
          end
        end
        default: o.status = 1'b1;
      endcase
      awaited.push_back(o);
    endfunction

    // accepted result against the oldest outcome; faults left in the queue
    function void check_result(logic st, logic [63:0] d);
      outcome_t o;
      if (awaited.size() == 0) begin
        faults.push_back($sformatf("result with nothing awaited: %h/%0b", d, st));
        return;
      end
      o = awaited.pop_front();
      if (st !== o.status)
        faults.push_back($sformatf("status %0b, want %0b", st, o.status));
      if (d[15:0] !== o.amp_re)
        faults.push_back($sformatf("amp_re %h, want %h", d[15:0], o.amp_re));
      if (d[31:16] !== o.amp_im)
        faults.push_back($sformatf("amp_im %h, want %h", d[31:16], o.amp_im));
      if (d[63:32] !== o.prob)
        faults.push_back($sformatf("probability %h, want %h", d[63:32], o.prob));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  amp_scoreboard sb = new();
  int errors = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  state_vector_gate_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // result side: check each transfer, then pick the next ready value
  initial begin : receiver
    int stall_left;
    int mode;
    stall_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tuser[0], out_tdata);
        while (sb.faults.size() != 0) report(sb.faults.pop_front());
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 400;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (mode == 0) out_tready <= 1'b1;
      else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // stop when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  int burst_left = 0;

  // offer one request and wait for its transfer; gaps only between bursts
  task automatic send_request(request_t r);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {6'b0, r.idx, r.cq, r.tq, r.eim, r.ere, r.col, r.row};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_request(r);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_qubits(logic [3:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'd0;
    cfg_pwdata <= {28'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.qubits = value;
  endtask

  function automatic request_t make_request(logic [2:0] kind);
    request_t r;
    r.kind = kind;
    r.row = $urandom_range(0, 3);
    r.col = $urandom_range(0, 3);
    r.ere = $urandom();
    r.eim = $urandom();
    r.tq = $urandom_range(0, 7);
    r.cq = $urandom_range(0, 7);
    r.idx = $urandom_range(0, 255);
    return r;
  endfunction

  // random request; gate_pct keeps the slow gate passes rare at large sizes
  function automatic request_t random_request(int gate_pct);
    request_t r;
    int n, pick;
    n = (sb.qubits > 8) ? 8 : sb.qubits;
    pick = $urandom_range(0, 99);
    if (pick < 4) r = make_request(svge_pkg::REQ_CLEAR);
    else if (pick < 4 + gate_pct) r = make_request(svge_pkg::REQ_SINGLE);
    else if (pick < 4 + 2 * gate_pct) r = make_request(svge_pkg::REQ_TWO);
    else if (pick < 70) r = make_request(svge_pkg::REQ_MATRIX);
    else if (pick < 95) r = make_request(svge_pkg::REQ_READ);
    else r = make_request(3'($urandom_range(UNKNOWN_REQ, 7)));
    if (n > 0 && $urandom_range(0, 4) != 0) begin
      r.tq = $urandom_range(0, n - 1);
      r.cq = $urandom_range(0, n - 1);
      r.idx = $urandom_range(0, (1 << n) - 1);
    end
    // mostly near-unit entries so the vector does not saturate at once
    if ($urandom_range(0, 9) < 7) begin
      r.ere = 16'($urandom_range(0, 32767) - 16384);
      r.eim = 16'($urandom_range(0, 16383) - 8192);
    end
    return r;
  endfunction

  task automatic directed_part();
    request_t r;
    r = make_request(svge_pkg::REQ_READ); r.idx = 8'd0; send_request(r);
    r = make_request(svge_pkg::REQ_READ); r.idx = 8'd15; send_request(r);
    r = make_request(svge_pkg::REQ_READ); r.idx = 8'd16; send_request(r);
    // hadamard-like 2x2 in the top-left corner
    r = make_request(svge_pkg::REQ_MATRIX);
    r.row = 0; r.col = 0; r.ere = 16'h2D41; r.eim = 0;
    send_request(r);
    r.col = 1; send_request(r);
    r.row = 1; r.col = 0; send_request(r);
    r.col = 1; r.ere = -16'sh2D41; send_request(r);
    r = make_request(svge_pkg::REQ_SINGLE); r.tq = 0; send_request(r);
    r = make_request(svge_pkg::REQ_SINGLE); r.tq = 3; send_request(r);
    r = make_request(svge_pkg::REQ_SINGLE); r.tq = 4; send_request(r);
    r = make_request(svge_pkg::REQ_READ); r.idx = 8'd9; send_request(r);
    // extreme entries to force saturation
    r = make_request(svge_pkg::REQ_MATRIX);
    r.row = 3; r.col = 3; r.ere = 16'h7FFF; r.eim = 16'h8000;
    send_request(r);
    r.row = 2; r.col = 3; r.ere = 16'h8000; r.eim = 16'h7FFF; send_request(r);
    r = make_request(svge_pkg::REQ_TWO); r.cq = 2; r.tq = 2; send_request(r);
    r = make_request(svge_pkg::REQ_TWO); r.cq = 5; r.tq = 1; send_request(r);
    r = make_request(svge_pkg::REQ_TWO); r.cq = 3; r.tq = 2; send_request(r);
    r = make_request(svge_pkg::REQ_READ); r.idx = 8'd12; send_request(r);
    r = make_request(svge_pkg::REQ_READ); r.idx = 8'd4; send_request(r);
    for (int k = UNKNOWN_REQ; k <= 7; k++) send_request(make_request(3'(k)));
    r = make_request(svge_pkg::REQ_CLEAR); send_request(r);
    r = make_request(svge_pkg::REQ_READ); r.idx = 8'd0; send_request(r);
  endtask

  // qubit counts per phase, reset value first; 0 and 15 reach the corner cases
  int phase_qubits[8] = '{4, 1, 8, 0, 15, 2, 3, 5};

  initial begin : stimulus
    int gate_pct;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    directed_part();
    for (int p = 0; p < 8; p++) begin
      if (p != 0) write_qubits(4'(phase_qubits[p]));
      gate_pct = (phase_qubits[p] >= 8) ? 2 : 15;
      // long receiver hold-off while requests keep coming
      if (p == 1) hold_request = 1'b1;
      repeat (70) send_request(random_request(gate_pct));
      // pause until every outcome is in, then go on
      if (p == 2) drain();
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
